[rtl/mca_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mca_pkg
// Shared widths, operation codes and pipeline stage type of the modular
// coefficient ALU.
// ----------------------------------------------------------------------------
package mca_pkg;

   localparam int COEFF_W = 32;
   localparam int MODE_W  = 2;
   localparam int PROD_W  = 2 * COEFF_W;
   localparam int MOD_W   = COEFF_W + 1;   // modulus with zero mapped to 2^32
   localparam int REDUCE_STAGES = PROD_W;  // one quotient bit per stage

   localparam logic [MODE_W-1:0] MODE_MUL_ADD = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ADD     = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SUB     = 2'd2;
   localparam logic [MODE_W-1:0] MODE_MUL     = 2'd3;

   // One slot of the reduction pipeline: partial remainder and the dividend
   // bits still to be shifted in (MSB first).
   typedef struct packed {
      logic               valid;
      logic               bypass;
      logic [COEFF_W-1:0] rem;
      logic [PROD_W-1:0]  value;
   } mca_stage_type;

endpackage
`default_nettype wire

[rtl/modular_coefficient_alu_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// modular_coefficient_alu_core
// Modular multiply-add / add / subtract / multiply of one coefficient.
//
// Usage:
//   Request: drive req_mode, req_a_coeff, req_b_coeff, req_c_coeff and raise
//   start; the request is taken at a clock edge with start high and busy low.
//   busy is high only while reset is asserted, so a new request can be taken
//   on every clock cycle.
//   Response: rsp_valid strobes for one cycle with rsp_result_coeff, in request
//   order. The receiver must take it in that cycle; there is no backpressure.
//   Pipeline: operand capture, 32x32 multiply and dividend select, then the
//   restoring division chain, one dividend bit per stage, which sets the depth.
//   Throughput is one request per cycle.
//   Modulus: csr_wr_en / csr_wr_data load Q; 0 means 2^32. Write it only with
//   no request in flight. Reset loads 2^32-1 and drops all requests in flight.
// ----------------------------------------------------------------------------
module modular_coefficient_alu_core
   import mca_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [MODE_W-1:0]  req_mode,
   input  wire logic [COEFF_W-1:0] req_a_coeff,
   input  wire logic [COEFF_W-1:0] req_b_coeff,
   input  wire logic [COEFF_W-1:0] req_c_coeff,
   input  wire logic               csr_wr_en,
   input  wire logic [COEFF_W-1:0] csr_wr_data,
   output logic                    rsp_valid,
   output logic [COEFF_W-1:0]      rsp_result_coeff
);

   logic [COEFF_W-1:0] modulus_ff;
   logic [MOD_W-1:0]   modulus_ext;
   logic               req_accept;
   mca_stage_type      stage_first;
   mca_stage_type      stage_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= '1;
      end else if (csr_wr_en) begin
         modulus_ff <= csr_wr_data;
      end
   end

   // zero modulus stands for 2^32
   assign modulus_ext = {(modulus_ff == '0), modulus_ff};

   assign busy       = reset;
   assign req_accept = start && !busy;

   mca_operand u_operand (
      .clock       (clock),
      .reset       (reset),
      .req_accept  (req_accept),
      .req_mode    (req_mode),
      .req_a_coeff (req_a_coeff),
      .req_b_coeff (req_b_coeff),
      .req_c_coeff (req_c_coeff),
      .modulus_ext (modulus_ext),
      .stage_out   (stage_first)
   );

   mca_reducer u_reducer (
      .clock       (clock),
      .reset       (reset),
      .modulus_ext (modulus_ext),
      .stage_first (stage_first),
      .stage_last  (stage_last)
   );

   assign rsp_valid        = stage_last.valid;
   assign rsp_result_coeff = stage_last.rem;

endmodule
`default_nettype wire

[rtl/mca_operand.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mca_operand
// Front end: registers the request, forms the product, sum and difference,
// then selects the 64-bit dividend for the reducer (or a finished result).
// ----------------------------------------------------------------------------
module mca_operand
   import mca_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_accept,
   input  wire logic [MODE_W-1:0]  req_mode,
   input  wire logic [COEFF_W-1:0] req_a_coeff,
   input  wire logic [COEFF_W-1:0] req_b_coeff,
   input  wire logic [COEFF_W-1:0] req_c_coeff,
   input  wire logic [MOD_W-1:0]   modulus_ext,
   output mca_stage_type           stage_out
);

   // stage 1: request capture
   logic               valid_s1_ff;
   logic [MODE_W-1:0]  mode_s1_ff;
   logic [COEFF_W-1:0] a_s1_ff;
   logic [COEFF_W-1:0] b_s1_ff;
   logic [COEFF_W-1:0] c_s1_ff;

   // stage 2: arithmetic
   logic               valid_s2_ff;
   logic [MODE_W-1:0]  mode_s2_ff;
   logic [PROD_W-1:0]  prod_s2_ff;
   logic [COEFF_W:0]   sum_s2_ff;
   logic [COEFF_W-1:0] diff_s2_ff;
   logic [COEFF_W-1:0] c_s2_ff;

   // stage 3: dividend select
   mca_stage_type      stage_in;
   mca_stage_type      stage_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_s1_ff <= 1'b0;
         valid_s2_ff <= 1'b0;
      end else begin
         valid_s1_ff <= req_accept;
         valid_s2_ff <= valid_s1_ff;
      end
   end

   always_ff @(posedge clock) begin
      mode_s1_ff <= req_mode;
      a_s1_ff    <= req_a_coeff;
      b_s1_ff    <= req_b_coeff;
      c_s1_ff    <= req_c_coeff;

      mode_s2_ff <= mode_s1_ff;
      prod_s2_ff <= PROD_W'(a_s1_ff) * PROD_W'(b_s1_ff);
      sum_s2_ff  <= {1'b0, a_s1_ff} + {1'b0, b_s1_ff};
      // wraps modulo 2^32; a zero modulus leaves a - b
      diff_s2_ff <= a_s1_ff + modulus_ext[COEFF_W-1:0] - b_s1_ff;
      c_s2_ff    <= c_s1_ff;
   end

   always_comb begin
      stage_in.valid  = valid_s2_ff;
      stage_in.bypass = 1'b0;
      stage_in.rem    = '0;
      stage_in.value  = '0;
      case (mode_s2_ff)
         MODE_MUL_ADD: begin
            stage_in.value = prod_s2_ff + {{COEFF_W{1'b0}}, c_s2_ff};
         end
         MODE_ADD: begin
            stage_in.value = {{(PROD_W-COEFF_W-1){1'b0}}, sum_s2_ff};
         end
         MODE_SUB: begin
            // single conditional subtract; the result passes through the reducer unchanged
            stage_in.bypass = 1'b1;
            if ({1'b0, diff_s2_ff} >= modulus_ext) begin
               stage_in.rem = diff_s2_ff - modulus_ext[COEFF_W-1:0];
            end else begin
               stage_in.rem = diff_s2_ff;
            end
         end
         MODE_MUL: begin
            stage_in.value = prod_s2_ff;
         end
         default: begin
            stage_in.value = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign stage_out = stage_ff;

endmodule
`default_nettype wire

[rtl/mca_reduce_stage.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mca_reduce_stage
// One step of restoring division: shift in the next dividend bit and
// subtract the modulus when the partial remainder reaches it.
// ----------------------------------------------------------------------------
module mca_reduce_stage
   import mca_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [MOD_W-1:0] modulus_ext,
   input  wire mca_stage_type    stage_prev,
   output mca_stage_type         stage_out
);

   logic [MOD_W-1:0] trial;
   logic [MOD_W:0]   diff;
   mca_stage_type    stage_in;
   mca_stage_type    stage_ff;

   always_comb begin
      trial    = {stage_prev.rem, stage_prev.value[PROD_W-1]};
      diff     = {1'b0, trial} - {1'b0, modulus_ext};
      stage_in = stage_prev;
      if (!stage_prev.bypass) begin
         stage_in.value = {stage_prev.value[PROD_W-2:0], 1'b0};
         // no borrow: trial >= modulus, keep the difference
         if (!diff[MOD_W]) begin
            stage_in.rem = diff[COEFF_W-1:0];
         end else begin
            stage_in.rem = trial[COEFF_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign stage_out = stage_ff;

endmodule
`default_nettype wire

[rtl/mca_reducer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mca_reducer
// Reduction steps, one dividend bit each; unless bypassed, gives value mod Q.
// ----------------------------------------------------------------------------
module mca_reducer
   import mca_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [MOD_W-1:0] modulus_ext,
   input  wire mca_stage_type    stage_first,
   output mca_stage_type         stage_last
);

   mca_stage_type chain [REDUCE_STAGES+1];

   assign chain[0] = stage_first;

   for (genvar k = 0; k < REDUCE_STAGES; k++) begin : g_step
      mca_reduce_stage u_step (
         .clock       (clock),
         .reset       (reset),
         .modulus_ext (modulus_ext),
         .stage_prev  (chain[k]),
         .stage_out   (chain[k+1])
      );
   end

   assign stage_last = chain[REDUCE_STAGES];

endmodule
`default_nettype wire
